// File: hw/rtl/km3_pkg.sv
// shared constants for the three-cluster 2-d k-means core
package km3_pkg;

    localparam int MAX_POINTS_DEF   = 65536;
    localparam int COORD_BITS_DEF   = 10;
    localparam int NUM_CLUSTERS_DEF = 3;

    localparam int LABEL_W    = 2;
    localparam int READ_IDX_W = 16;
    localparam int PASS_W     = 8;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 1'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_CENTROID = 1'b0;
    localparam logic KIND_LABEL    = 1'b1;

    localparam logic [LABEL_W-1:0] NO_LABEL = 2'd3;

    localparam logic [PASS_W-1:0]     MAX_ITER_RST = 8'd255;
    localparam logic [CFG_DATA_W-1:0] RELAX_RST    = 17'd0;

endpackage

// File: hw/rtl/km3_ram.sv
// generic simple dual-port ram with registered read
module km3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/km3_div.sv
// iterative restoring divider, one quotient bit per cycle
module km3_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
                r_quo  <= {r_quo[NUM_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: hw/rtl/kmeans_three_cluster_2d_core.sv
// top level of the three-cluster 2-d k-means core
//
// input stream s_axis: tuser is the opcode (load point or read label), tlast marks the
// final point of a batch. a load is written to the point ram as it is accepted; the first
// load after a finished run starts a new batch. a load with tlast starts clustering.
// a read returns one label result by way of the states S_RDWAIT and S_RDOUT, waiting in
// S_RDOUT while m_axis stalls. clustering walks the point ram once per pass to sum, runs
// six serial divisions (skipped for empty clusters), walks it again to relabel and ends
// each pass with the stop test in S_CHECK, all through the single read port of the ram;
// no input is taken while a run is in progress, and the next input is taken once the
// last centroid result has entered the output register.
// output stream m_axis: tuser is the result kind, tlast marks the last result of an
// input transaction. when m_axis_tready is low the output register holds its
// transaction and the core waits; input is still taken while idle.
// reset (synchronous, active low) empties the point set, zeroes the centroids and
// sets relax_limit to 0 and max_iterations to 255.
// cfg: i_cfg_we writes register i_cfg_idx (0 relax_limit, 1 max_iterations).
module kmeans_three_cluster_2d_core #(
    parameter int MAX_POINTS   = km3_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS   = km3_pkg::COORD_BITS_DEF,
    parameter int NUM_CLUSTERS = km3_pkg::NUM_CLUSTERS_DEF,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int IN_RAW = 2 * COORD_BITS + km3_pkg::LABEL_W + km3_pkg::READ_IDX_W,
    localparam int IN_DW  = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = km3_pkg::LABEL_W + 2 * COORD_BITS + 1 + CNT_W
                             + km3_pkg::PASS_W,
    localparam int OUT_DW = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [km3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [km3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, start_label, read_index, zero pad
    input  logic [IN_DW-1:0]                s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    // final_point
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cluster, centroid_x, centroid_y, cluster_empty, last_changes, passes_done, zero pad
    output logic [OUT_DW-1:0]               m_axis_tdata,
    // result_kind
    output logic                            m_axis_tuser,
    // last_of_run
    output logic                            m_axis_tlast
);
    localparam int CB    = COORD_BITS;
    localparam int LW    = km3_pkg::LABEL_W;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int WW    = 2 * CB + LW;
    localparam int SUM_W = CB + CNT_W;
    localparam int DW    = 2 * CB + 1;
    localparam int CI_W  = $clog2(NUM_CLUSTERS);
    localparam int RI_W  = km3_pkg::READ_IDX_W;
    localparam int CMP_W = (CNT_W > RI_W) ? CNT_W : RI_W;
    localparam int RL_W  = (CNT_W > km3_pkg::CFG_DATA_W) ? CNT_W : km3_pkg::CFG_DATA_W;
    localparam int PW    = km3_pkg::PASS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_RDOUT, S_SUM, S_DIV, S_DIVWAIT, S_REL, S_CHECK, S_EMIT
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]                 r_count;
    logic                             r_batch_done;
    logic [km3_pkg::CFG_DATA_W-1:0]   r_relax;
    logic [PW-1:0]                    r_maxit;
    logic [PW-1:0]                    r_pass;
    logic [CNT_W-1:0]                 r_changes;
    logic [CB-1:0]                    r_cx [NUM_CLUSTERS];
    logic [CB-1:0]                    r_cy [NUM_CLUSTERS];
    logic [SUM_W-1:0]                 r_sumx [NUM_CLUSTERS];
    logic [SUM_W-1:0]                 r_sumy [NUM_CLUSTERS];
    logic [CNT_W-1:0]                 r_ccnt [NUM_CLUSTERS];
    logic [CNT_W-1:0]                 r_idx;
    logic                             r_v1;
    logic                             r_v2;
    logic [AW-1:0]                    r_a1;
    logic [AW-1:0]                    r_a2;
    logic [WW-1:0]                    r_w2;
    logic [2*CB-1:0]                  r_dx2 [NUM_CLUSTERS];
    logic [2*CB-1:0]                  r_dy2 [NUM_CLUSTERS];
    logic [CI_W-1:0]                  r_dc;
    logic                             r_da;
    logic [CI_W-1:0]                  r_ec;
    logic                             r_rd_ok;
    logic [LW-1:0]                    r_rd_lab;

    logic                             r_ovalid;
    logic                             r_okind;
    logic [LW-1:0]                    r_oclus;
    logic [CB-1:0]                    r_ocx;
    logic [CB-1:0]                    r_ocy;
    logic                             r_oempty;
    logic [CNT_W-1:0]                 r_ochg;
    logic [PW-1:0]                    r_opass;
    logic                             r_olast;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [WW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [WW-1:0]    mem_rdata;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    logic             in_acc;
    logic             out_free;
    logic [CNT_W-1:0] cnt_eff;
    logic [CB-1:0]    in_x;
    logic [CB-1:0]    in_y;
    logic [LW-1:0]    in_lab;
    logic [RI_W-1:0]  in_ridx;
    logic [CB-1:0]    m_x;
    logic [CB-1:0]    m_y;
    logic [LW-1:0]    m_lab;
    logic [CB-1:0]    p2_x;
    logic [CB-1:0]    p2_y;
    logic [LW-1:0]    p2_lab;
    logic [DW-1:0]    sq_dist [NUM_CLUSTERS];
    logic [DW-1:0]    best_d;
    logic [LW-1:0]    best;
    logic             rel_wr;
    logic [PW-1:0]    pass_nx;
    logic             scan_left;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign cnt_eff   = r_batch_done ? '0 : r_count;
    assign in_x      = s_axis_tdata[CB-1:0];
    assign in_y      = s_axis_tdata[2*CB-1:CB];
    assign in_lab    = s_axis_tdata[WW-1:2*CB];
    assign in_ridx   = s_axis_tdata[WW+RI_W-1:WW];
    assign m_x       = mem_rdata[CB-1:0];
    assign m_y       = mem_rdata[2*CB-1:CB];
    assign m_lab     = mem_rdata[WW-1:2*CB];
    assign p2_x      = r_w2[CB-1:0];
    assign p2_y      = r_w2[2*CB-1:CB];
    assign p2_lab    = r_w2[WW-1:2*CB];
    assign pass_nx   = r_pass + 1'b1;
    assign scan_left = r_idx < r_count;
    assign s_axis_tready = (r_state == S_IDLE);

    // nearest centroid, ties to the lower cluster
    always_comb begin
        for (int c = 0; c < NUM_CLUSTERS; c++) begin
            sq_dist[c] = DW'(r_dx2[c]) + DW'(r_dy2[c]);
        end
        best_d = sq_dist[0];
        best   = '0;
        for (int c = 1; c < NUM_CLUSTERS; c++) begin
            if (sq_dist[c] < best_d) begin
                best_d = sq_dist[c];
                best   = LW'(c);
            end
        end
        rel_wr = (r_state == S_REL) && r_v2 && (best != p2_lab);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_a2;
        mem_wdata = {best, p2_y, p2_x};
        mem_raddr = r_idx[AW-1:0];
        if (r_state == S_IDLE) begin
            mem_raddr = AW'(in_ridx);
            mem_waddr = cnt_eff[AW-1:0];
            mem_wdata = {in_lab, in_y, in_x};
            mem_we    = in_acc && (s_axis_tuser == km3_pkg::OP_LOAD)
                        && (cnt_eff < CNT_W'(MAX_POINTS));
        end else if (rel_wr) begin
            mem_we = 1'b1;
        end
    end

    assign div_start = (r_state == S_DIV) && (r_ccnt[r_dc] != '0);

    km3_ram #(.WIDTH(WW), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    km3_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_da ? r_sumy[r_dc] : r_sumx[r_dc]),
        .i_den   (r_ccnt[r_dc]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_batch_done <= 1'b0;
            r_relax      <= km3_pkg::RELAX_RST;
            r_maxit      <= km3_pkg::MAX_ITER_RST;
            r_pass       <= '0;
            r_changes    <= '0;
            r_idx        <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_dc         <= '0;
            r_da         <= 1'b0;
            r_ec         <= '0;
            r_ovalid     <= 1'b0;
            for (int c = 0; c < NUM_CLUSTERS; c++) begin
                r_cx[c]   <= '0;
                r_cy[c]   <= '0;
                r_sumx[c] <= '0;
                r_sumy[c] <= '0;
                r_ccnt[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    km3_pkg::CFG_RELAX_LIMIT: r_relax <= i_cfg_data;
                    km3_pkg::CFG_MAX_ITER:    r_maxit <= PW'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser == km3_pkg::OP_READ) begin
                            r_rd_ok <= CMP_W'(in_ridx) < CMP_W'(r_count);
                            r_state <= S_RDWAIT;
                        end else begin
                            r_batch_done <= 1'b0;
                            r_count <= (cnt_eff < CNT_W'(MAX_POINTS)) ? cnt_eff + 1'b1
                                                                       : cnt_eff;
                            if (s_axis_tlast) begin
                                r_pass  <= '0;
                                r_state <= S_SUM;
                                r_idx   <= '0;
                                r_v1    <= 1'b0;
                                for (int c = 0; c < NUM_CLUSTERS; c++) begin
                                    r_sumx[c] <= '0;
                                    r_sumy[c] <= '0;
                                    r_ccnt[c] <= '0;
                                end
                            end
                        end
                    end
                end
                S_RDWAIT: begin
                    r_rd_lab <= (r_rd_ok && m_lab < LW'(NUM_CLUSTERS)) ? m_lab
                                                                       : km3_pkg::NO_LABEL;
                    r_state  <= S_RDOUT;
                end
                S_RDOUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= km3_pkg::KIND_LABEL;
                        r_oclus  <= r_rd_lab;
                        r_ocx    <= '0;
                        r_ocy    <= '0;
                        r_oempty <= 1'b0;
                        r_ochg   <= '0;
                        r_opass  <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SUM: begin
                    r_v1 <= scan_left;
                    if (scan_left) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_v1) begin
                        for (int c = 0; c < NUM_CLUSTERS; c++) begin
                            if (m_lab == LW'(c)) begin
                                r_ccnt[c] <= r_ccnt[c] + 1'b1;
                                r_sumx[c] <= r_sumx[c] + SUM_W'(m_x);
                                r_sumy[c] <= r_sumy[c] + SUM_W'(m_y);
                            end
                        end
                    end else if (!scan_left) begin
                        r_dc    <= '0;
                        r_da    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV, S_DIVWAIT: begin
                    if (r_state == S_DIV && div_start) begin
                        r_state <= S_DIVWAIT;
                    end else if (r_state == S_DIV || div_done) begin
                        if (r_state == S_DIVWAIT) begin
                            if (r_da) begin
                                r_cy[r_dc] <= div_quo[CB-1:0];
                            end else begin
                                r_cx[r_dc] <= div_quo[CB-1:0];
                            end
                        end
                        r_state <= S_DIV;
                        r_da    <= !r_da;
                        if (r_da || r_state == S_DIV) begin
                            r_da <= 1'b0;
                            if (r_dc == CI_W'(NUM_CLUSTERS - 1)) begin
                                r_state   <= S_REL;
                                r_idx     <= '0;
                                r_v1      <= 1'b0;
                                r_v2      <= 1'b0;
                                r_changes <= '0;
                            end else begin
                                r_dc <= r_dc + 1'b1;
                            end
                        end
                    end
                end
                S_REL: begin
                    r_v1 <= scan_left;
                    r_a1 <= r_idx[AW-1:0];
                    if (scan_left) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_v2 <= r_v1;
                    r_a2 <= r_a1;
                    r_w2 <= mem_rdata;
                    for (int c = 0; c < NUM_CLUSTERS; c++) begin
                        r_dx2[c] <= (m_x > r_cx[c]) ? (m_x - r_cx[c]) * (m_x - r_cx[c])
                                                    : (r_cx[c] - m_x) * (r_cx[c] - m_x);
                        r_dy2[c] <= (m_y > r_cy[c]) ? (m_y - r_cy[c]) * (m_y - r_cy[c])
                                                    : (r_cy[c] - m_y) * (r_cy[c] - m_y);
                    end
                    if (rel_wr) begin
                        r_changes <= r_changes + 1'b1;
                    end
                    if (!scan_left && !r_v1 && !r_v2) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_pass <= pass_nx;
                    if (RL_W'(r_changes) > RL_W'(r_relax) && pass_nx < r_maxit) begin
                        r_state <= S_SUM;
                        r_idx   <= '0;
                        r_v1    <= 1'b0;
                        for (int c = 0; c < NUM_CLUSTERS; c++) begin
                            r_sumx[c] <= '0;
                            r_sumy[c] <= '0;
                            r_ccnt[c] <= '0;
                        end
                    end else begin
                        r_batch_done <= 1'b1;
                        r_ec         <= '0;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= km3_pkg::KIND_CENTROID;
                        r_oclus  <= LW'(r_ec);
                        r_ocx    <= r_cx[r_ec];
                        r_ocy    <= r_cy[r_ec];
                        r_oempty <= (r_ccnt[r_ec] == '0);
                        r_ochg   <= r_changes;
                        r_opass  <= r_pass;
                        r_olast  <= (r_ec == CI_W'(NUM_CLUSTERS - 1));
                        r_ec     <= r_ec + 1'b1;
                        if (r_ec == CI_W'(NUM_CLUSTERS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = OUT_DW'({r_opass, r_ochg, r_oempty, r_ocy, r_ocx, r_oclus});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE || r_state == S_REL))
        else $error("point ram written outside load or relabel");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_ccnt[r_dc] != '0))
        else $error("division by an empty cluster count");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_ovalid && r_okind == km3_pkg::KIND_CENTROID))
        else $error("centroid result not presented");
endmodule

// File: tb/sv/km3_result_checker.sv
// checker for the k-means core: predicts centroid and label results and compares them
`timescale 1ns / 100ps
module km3_result_checker
    import km3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [47:0]           m_axis_tdata,
    input  logic                  m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int STORE_DEPTH = 65536;

    typedef struct packed {
        logic        kind;
        logic [1:0]  cluster;
        logic [9:0]  cx;
        logic [9:0]  cy;
        logic        empty;
        logic [16:0] changes;
        logic [7:0]  passes;
        logic        last;
    } km_result_t;

    km_result_t due_results[$];

    logic [9:0] pt_x[STORE_DEPTH];
    logic [9:0] pt_y[STORE_DEPTH];
    logic [1:0] pt_lab[STORE_DEPTH];
    int         pt_count;
    int         cent[3][2];
    longint     sums[3][2];
    int         counts[3];
    int         relax_limit;
    int         max_iter;
    bit         batch_done;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic longint sq(input int a, input int b);
        longint d;
        d = a - b;
        return d * d;
    endfunction

    function automatic int refine_pass();
        int     changes;
        int     best;
        longint best_d;
        longint d;
        changes = 0;
        for (int c = 0; c < 3; c++) begin
            sums[c][0] = 0;
            sums[c][1] = 0;
            counts[c] = 0;
        end
        for (int i = 0; i < pt_count; i++) begin
            if (pt_lab[i] < 3) begin
                counts[pt_lab[i]]++;
                sums[pt_lab[i]][0] += pt_x[i];
                sums[pt_lab[i]][1] += pt_y[i];
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (counts[c] != 0) begin
                cent[c][0] = int'(sums[c][0] / counts[c]);
                cent[c][1] = int'(sums[c][1] / counts[c]);
            end
        end
        for (int i = 0; i < pt_count; i++) begin
            best = 0;
            best_d = sq(pt_x[i], cent[0][0]) + sq(pt_y[i], cent[0][1]);
            for (int c = 1; c < 3; c++) begin
                d = sq(pt_x[i], cent[c][0]) + sq(pt_y[i], cent[c][1]);
                if (d < best_d) begin
                    best_d = d;
                    best = c;
                end
            end
            if (pt_lab[i] != best) begin
                pt_lab[i] = best[1:0];
                changes++;
            end
        end
        return changes;
    endfunction

    task automatic predict_item(input logic op, input logic [39:0] data, input logic fin);
        km_result_t r;
        int         idx;
        int         changes;
        int         passes;
        r = '0;
        if (op == OP_READ) begin
            idx = data[37:22];
            r.kind = KIND_LABEL;
            r.cluster = NO_LABEL;
            if (idx < pt_count && pt_lab[idx] < 3) r.cluster = pt_lab[idx];
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            if (batch_done) begin
                pt_count = 0;
                batch_done = 0;
            end
            if (pt_count < STORE_DEPTH) begin
                pt_x[pt_count] = data[9:0];
                pt_y[pt_count] = data[19:10];
                pt_lab[pt_count] = data[21:20];
                pt_count++;
            end
            if (fin) begin
                passes = 0;
                do begin
                    changes = refine_pass();
                    passes = (passes + 1) & 8'hFF;
                end while (changes > relax_limit && passes < max_iter);
                batch_done = 1;
                for (int c = 0; c < 3; c++) begin
                    r.kind = KIND_CENTROID;
                    r.cluster = c[1:0];
                    r.cx = cent[c][0][9:0];
                    r.cy = cent[c][1][9:0];
                    r.empty = (counts[c] == 0);
                    r.changes = changes[16:0];
                    r.passes = passes[7:0];
                    r.last = (c == 2);
                    due_results.push_back(r);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        km_result_t e;
        if (!i_rst_n) begin
            pt_count = 0;
            batch_done = 0;
            relax_limit = RELAX_RST;
            max_iter = MAX_ITER_RST;
            for (int c = 0; c < 3; c++) begin
                cent[c][0] = 0;
                cent[c][1] = 0;
                counts[c] = 0;
            end
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RELAX_LIMIT) relax_limit = i_cfg_data;
                else if (i_cfg_idx == CFG_MAX_ITER) max_iter = i_cfg_data[7:0];
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t unexpected result transaction: expected none actual %h",
                             $time, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    e = due_results.pop_front();
                    check_field("result_kind", e.kind, m_axis_tuser);
                    check_field("cluster", e.cluster, m_axis_tdata[1:0]);
                    check_field("centroid_x", e.cx, m_axis_tdata[11:2]);
                    check_field("centroid_y", e.cy, m_axis_tdata[21:12]);
                    check_field("cluster_empty", e.empty, m_axis_tdata[22]);
                    check_field("last_changes", e.changes, m_axis_tdata[39:23]);
                    check_field("passes_done", e.passes, m_axis_tdata[47:40]);
                    check_field("last_of_run", e.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
        o_pending = due_results.size();
    end

endmodule

// File: tb/sv/tb_kmeans_three_cluster_2d_core.sv
// testbench top for the k-means core: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_kmeans_three_cluster_2d_core;
    import km3_pkg::*;

    localparam int CYCLE_LIMIT = 100000000;
    localparam int RANDOM_ITEMS = 420;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    rx_mode = 0;
    int                    items_sent = 0;

    always #1 i_clk = ~i_clk;

    kmeans_three_cluster_2d_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    km3_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 5) == 0);
            default: m_axis_tready <= (cycle_count % 7 < 4);
        endcase
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [9:0] x, input logic [9:0] y,
                             input logic [1:0] lab, input logic [15:0] idx,
                             input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tlast <= fin;
        s_axis_tdata <= {2'b00, idx, lab, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        items_sent++;
    endtask

    task automatic load_pt(input int x, input int y, input int lab, input bit fin);
        send_item(OP_LOAD, x[9:0], y[9:0], lab[1:0], 16'($urandom), fin);
    endtask

    task automatic read_pt(input int idx);
        send_item(OP_READ, 10'($urandom), 10'($urandom), 2'($urandom), idx[15:0],
                  1'($urandom));
    endtask

    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_batch();
        int n;
        int cx[3];
        int cy[3];
        int k;
        int x;
        int y;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        for (int c = 0; c < 3; c++) begin
            cx[c] = $urandom_range(0, 1023);
            cy[c] = $urandom_range(0, 1023);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end else begin
                k = $urandom_range(0, 2);
                x = cx[k] + $urandom_range(0, 60) - 30;
                y = cy[k] + $urandom_range(0, 60) - 30;
                x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
                y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
            end
            load_pt(x, y, ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2), i == n - 1);
            if ($urandom_range(0, 4) == 0)
                read_pt(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 12));
        end
        repeat ($urandom_range(0, 3)) read_pt($urandom_range(0, n));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        read_pt(0);
        send_item(OP_READ, 10'd0, 10'd0, 2'd0, 16'hFFFF, 1'b1);
        drain_idle();
        write_reg(CFG_RELAX_LIMIT, 0);
        write_reg(CFG_MAX_ITER, 255);
        load_pt(0, 0, 0, 0);
        load_pt(1023, 1023, 1, 0);
        load_pt(1023, 0, 2, 0);
        load_pt(0, 1023, 3, 0);
        load_pt(512, 512, 0, 1);
        for (int i = 0; i < 5; i++) read_pt(i);
        read_pt(65535);
        load_pt(10, 20, 0, 0);
        load_pt(30, 40, 0, 1);
        load_pt(100, 100, 0, 0);
        load_pt(100, 100, 1, 1);
        read_pt(1);
        drain_idle();
        write_reg(CFG_MAX_ITER, 0);
        write_reg(CFG_RELAX_LIMIT, 65536);
        load_pt(5, 900, 2, 0);
        load_pt(800, 3, 1, 0);
        load_pt(400, 400, 0, 1);
        drain_idle();

        // random part
        while (items_sent < RANDOM_ITEMS) begin
            drain_idle();
            case ($urandom_range(0, 4))
                0: write_reg(CFG_RELAX_LIMIT, 0);
                1: write_reg(CFG_RELAX_LIMIT, 65536);
                default: write_reg(CFG_RELAX_LIMIT, $urandom_range(0, 4));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_MAX_ITER, 1);
                1: write_reg(CFG_MAX_ITER, 255);
                2: write_reg(CFG_MAX_ITER, 0);
                default: write_reg(CFG_MAX_ITER, $urandom_range(1, 20));
            endcase
            repeat ($urandom_range(1, 5)) random_batch();
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
